/* rtl/core/tcfq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfq_pkg: shared types for the timed CAN frame queue
// Frame and table entry layouts, result codes, register indexes, FSM states.
// ----------------------------------------------------------------------------
package tcfq_pkg;

  localparam int IdentW   = 29;
  localparam int LenW     = 4;
  localparam int PayloadW = 64;
  localparam int TimeW    = 16;
  localparam int NowW     = 32;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 64;

  typedef struct packed {
    logic [IdentW-1:0]   ident;
    logic                extended;
    logic [LenW-1:0]     length;
    logic [PayloadW-1:0] payload;
  } frame_t;

  typedef struct packed {
    frame_t           frame;
    logic [TimeW-1:0] send_time;
  } entry_t;

  typedef enum logic [1:0] {
    STATUS_ACCEPTED = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_QUEUED   = 2'd2,
    STATUS_DEFAULT  = 2'd3
  } status_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_DEF_IDENT    = 2'd0,
    CFG_DEF_EXTENDED = 2'd1,
    CFG_DEF_LENGTH   = 2'd2,
    CFG_DEF_PAYLOAD  = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

endpackage

/* rtl/core/timed_can_frame_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_can_frame_queue_top: compacted queue of timed CAN frames
// Enqueue appends a frame with its send time; a request removes the
// highest-index entry whose time is at or after now, or returns the default.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | in_valid_i/in_ready_o  | func, frame_*, send_time, now_ms
//  out     | out_valid_o/out_ready_i| status, out_ident/extended/length/payload
//  cfg     | cfg_we_i (no wait)     | cfg_addr_i, cfg_wdata_i
//
//  Enqueue: accept + table write in idle, then result load in finish.
//  Request over n stored entries: scan s entries top-down (1..n), then
//  move m entries down after the pick (0..n-1), then load the result; the
//  single-port-read table RAM and one 32-bit time comparator serialise both.
//  Reset clears the entry count; table contents need no clearing.
//  in_ready_o is high only in idle; a stalled out beat holds the finished
//  result in the finish state until the out slot frees.
//
module timed_can_frame_queue_top #(
  parameter int QUEUE_DEPTH = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [tcfq_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [tcfq_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input beats
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic [tcfq_pkg::IdentW-1:0]    frame_ident_i,
  input  logic                           frame_extended_i,
  input  logic [tcfq_pkg::LenW-1:0]      frame_length_i,
  input  logic [tcfq_pkg::PayloadW-1:0]  frame_payload_i,
  input  logic [tcfq_pkg::TimeW-1:0]     send_time_i,
  input  logic [tcfq_pkg::NowW-1:0]      now_ms_i,
  // result beats
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [tcfq_pkg::IdentW-1:0]    out_ident_o,
  output logic                           out_extended_o,
  output logic [tcfq_pkg::LenW-1:0]      out_length_o,
  output logic [tcfq_pkg::PayloadW-1:0]  out_payload_o
);

  localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  // configuration registers (default frame)
  tcfq_pkg::frame_t default_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        tcfq_pkg::CFG_DEF_IDENT:    default_q.ident    <= cfg_wdata_i[tcfq_pkg::IdentW-1:0];
        tcfq_pkg::CFG_DEF_EXTENDED: default_q.extended <= cfg_wdata_i[0];
        tcfq_pkg::CFG_DEF_LENGTH:   default_q.length   <= cfg_wdata_i[tcfq_pkg::LenW-1:0];
        tcfq_pkg::CFG_DEF_PAYLOAD:  default_q.payload  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control state
  tcfq_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             out_valid_q, out_valid_d;

  // payload state
  logic [tcfq_pkg::NowW-1:0] now_q, now_d;
  tcfq_pkg::frame_t          res_frame_q, res_frame_d;
  tcfq_pkg::status_e         res_status_q, res_status_d;
  tcfq_pkg::frame_t          out_frame_q;
  tcfq_pkg::status_e         out_status_q;

  // table RAM
  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;
  tcfq_pkg::entry_t    ram_wdata;
  logic [IdxW-1:0]     ram_raddr;
  tcfq_pkg::entry_t    ram_rdata;

  tcfq_ram #(
    .Width ($bits(tcfq_pkg::entry_t)),
    .Depth (QUEUE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic             in_accept;
  logic             out_free;
  logic [CntW-1:0]  cnt_m1;
  logic [CntW-1:0]  idx_ext;
  logic             time_hit;
  logic [CntW-1:0]  idx_p1;
  logic [CntW-1:0]  idx_p2;
  tcfq_pkg::entry_t in_entry;

  assign in_ready_o = (state_q == tcfq_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign cnt_m1     = count_q - CntW'(1);
  assign idx_ext    = CntW'(idx_q);
  assign idx_p1     = idx_ext + CntW'(1);
  assign idx_p2     = idx_ext + CntW'(2);

  // shared comparator: stored time, zero-extended, against now
  assign time_hit = ({{(tcfq_pkg::NowW - tcfq_pkg::TimeW){1'b0}}, ram_rdata.send_time}
                     >= now_q);

  assign in_entry.frame.ident    = frame_ident_i;
  assign in_entry.frame.extended = frame_extended_i;
  assign in_entry.frame.length   = frame_length_i;
  assign in_entry.frame.payload  = frame_payload_i;
  assign in_entry.send_time      = send_time_i;

  // sequencer: enqueue, or scan for the top due entry and move later ones down
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    now_d        = now_q;
    res_frame_d  = res_frame_q;
    res_status_d = res_status_q;
    out_valid_d  = out_ready_i ? 1'b0 : out_valid_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[IdxW-1:0];
    ram_wdata    = in_entry;
    ram_raddr    = cnt_m1[IdxW-1:0];

    case (state_q)
      tcfq_pkg::ST_IDLE: begin
        if (in_accept) begin
          now_d = now_ms_i;
          if (func_i) begin
            if (count_q == '0) begin
              res_frame_d  = default_q;
              res_status_d = tcfq_pkg::STATUS_DEFAULT;
              state_d      = tcfq_pkg::ST_FINISH;
            end else begin
              idx_d   = cnt_m1[IdxW-1:0];
              state_d = tcfq_pkg::ST_SCAN;
            end
          end else begin
            res_frame_d = '0;
            if (count_q < CntW'(QUEUE_DEPTH)) begin
              ram_we       = 1'b1;
              count_d      = count_q + CntW'(1);
              res_status_d = tcfq_pkg::STATUS_ACCEPTED;
            end else begin
              res_status_d = tcfq_pkg::STATUS_FULL;
            end
            state_d = tcfq_pkg::ST_FINISH;
          end
        end
      end
      tcfq_pkg::ST_SCAN: begin
        if (time_hit) begin
          res_frame_d  = ram_rdata.frame;
          res_status_d = tcfq_pkg::STATUS_QUEUED;
          if (idx_ext == cnt_m1) begin
            count_d = cnt_m1;
            state_d = tcfq_pkg::ST_FINISH;
          end else begin
            ram_raddr = idx_p1[IdxW-1:0];
            state_d   = tcfq_pkg::ST_SHIFT;
          end
        end else if (idx_q == '0) begin
          res_frame_d  = default_q;
          res_status_d = tcfq_pkg::STATUS_DEFAULT;
          state_d      = tcfq_pkg::ST_FINISH;
        end else begin
          idx_d     = idx_q - IdxW'(1);
          ram_raddr = idx_q - IdxW'(1);
        end
      end
      tcfq_pkg::ST_SHIFT: begin
        // read data holds entry idx+1; it moves down to idx
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        if (idx_p1 == cnt_m1) begin
          count_d = cnt_m1;
          state_d = tcfq_pkg::ST_FINISH;
        end else begin
          idx_d     = idx_q + IdxW'(1);
          ram_raddr = idx_p2[IdxW-1:0];
        end
      end
      tcfq_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = tcfq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcfq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcfq_pkg::ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q        <= now_d;
    res_frame_q  <= res_frame_d;
    res_status_q <= res_status_d;
    if (state_q == tcfq_pkg::ST_FINISH && out_free) begin
      out_frame_q  <= res_frame_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_ident_o    = out_frame_q.ident;
  assign out_extended_o = out_frame_q.extended;
  assign out_length_o   = out_frame_q.length;
  assign out_payload_o  = out_frame_q.payload;

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcfq_pkg::ST_SHIFT) |-> (idx_p1 < count_q))
    else $error("shift source beyond last entry");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !func_i && count_q == CntW'(QUEUE_DEPTH)) |=> $stable(count_q))
    else $error("count changed on enqueue into full queue");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("ready again right after accepting a beat");
`endif

endmodule

/* rtl/core/tcfq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfq_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcfq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
